/* rtl/sbie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbie_pkg: shared types and constants for the integer bytecode executor
// Opcode codes, error codes, sequencer states and ALU operation codes.
// ----------------------------------------------------------------------------
package sbie_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int LOCAL_SLOTS = 16;
	localparam int SP_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int LOC_W = $clog2(LOCAL_SLOTS);

	// opcodes
	localparam logic [7:0] OP_ICONST_M1 = 8'h02;
	localparam logic [7:0] OP_ICONST_5 = 8'h08;
	localparam logic [7:0] OP_BIPUSH = 8'h10;
	localparam logic [7:0] OP_ILOAD = 8'h15;
	localparam logic [7:0] OP_ILOAD_0 = 8'h1A;
	localparam logic [7:0] OP_ILOAD_3 = 8'h1D;
	localparam logic [7:0] OP_ISTORE = 8'h36;
	localparam logic [7:0] OP_ISTORE_0 = 8'h3B;
	localparam logic [7:0] OP_ISTORE_3 = 8'h3E;
	localparam logic [7:0] OP_IADD = 8'h60;
	localparam logic [7:0] OP_ISUB = 8'h64;
	localparam logic [7:0] OP_IMUL = 8'h68;
	localparam logic [7:0] OP_IDIV = 8'h6C;
	localparam logic [7:0] OP_ISHL = 8'h78;
	localparam logic [7:0] OP_ISHR = 8'h7A;
	localparam logic [7:0] OP_IINC = 8'h84;
	localparam logic [7:0] OP_IFEQ = 8'h99;
	localparam logic [7:0] OP_IFLE = 8'h9E;
	localparam logic [7:0] OP_IF_ICMPEQ = 8'h9F;
	localparam logic [7:0] OP_IF_ICMPLE = 8'hA4;
	localparam logic [7:0] OP_GOTO = 8'hA7;
	localparam logic [7:0] OP_IRETURN = 8'hAC;
	localparam logic [7:0] OP_RETURN = 8'hB1;
	localparam logic [7:0] OP_GETSTATIC = 8'hB2;
	localparam logic [7:0] OP_INVOKEVIRTUAL = 8'hB6;

	// error codes
	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_OPCODE = 3'd1;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_DIVZERO = 3'd4;
	localparam logic [2:0] ERR_LOCAL = 3'd5;

	typedef enum logic [3:0] {
		K_PUSH, K_BINOP, K_STORE, K_IINC, K_CMP1, K_CMP2,
		K_GOTO, K_PRINT, K_RET, K_IRET, K_NOP
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_WRITE, ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		ALU_NONE, ALU_MUL, ALU_DIV
	} alu_op_t;

	// iterative unit control and status
	typedef struct packed {
		logic start;
		alu_op_t op;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_sts_t;

endpackage

/* rtl/sbie_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbie_ram: generic single-port RAM
// One write (when we is set) and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sbie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/sbie_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbie_muldiv: shared iterative multiply / divide unit
// Radix-2 shift-add multiply and restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
module sbie_muldiv
	import sbie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  alu_ctl_t    ctl,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output alu_sts_t    sts,
	output logic [31:0] result
);

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic [4:0]  step_q;
	logic [31:0] acc_q;    // product or quotient
	logic [31:0] rem_q;
	logic [31:0] mcand_q;  // multiplicand / divisor magnitude
	logic [31:0] mplier_q; // multiplier / dividend magnitude
	logic        neg_q;

	logic [32:0] trial;
	logic [31:0] rem_sh;
	logic [31:0] a_mag;
	logic [31:0] b_mag;

	assign a_mag = a[31] ? (~a + 32'd1) : a;
	assign b_mag = b[31] ? (~b + 32'd1) : b;
	assign rem_sh = {rem_q[30:0], mplier_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, mcand_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			op_q <= ALU_NONE;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				op_q <= ctl.op;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			rem_q <= '0;
			if (ctl.op == ALU_MUL) begin
				mcand_q <= a;
				mplier_q <= b;
			end else begin
				mcand_q <= b_mag;
				mplier_q <= a_mag;
			end
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			if (op_q == ALU_MUL) begin
				acc_q <= {acc_q[30:0], 1'b0} + (mplier_q[31] ? mcand_q : 32'd0);
				mplier_q <= {mplier_q[30:0], 1'b0};
			end else begin
				mplier_q <= {mplier_q[30:0], 1'b0};
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					acc_q <= {acc_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					acc_q <= {acc_q[30:0], 1'b0};
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	// quotient sign fixup; min / -1 wraps back to min on its own
	assign result = (op_q == ALU_DIV && neg_q) ? (~acc_q + 32'd1) : acc_q;

endmodule

/* rtl/stack_bytecode_integer_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_bytecode_integer_executor: JVM integer subset executor
// Runs one decoded instruction per transaction on an operand stack and locals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | opcode, local_index, immediate, ...
//  out     | output    | out_valid/stall| next_pc, print_*, done_res, ...
//
//  Most instructions pass from acceptance to the next acceptance through
//  accept, read of stack and local RAMs, execute, write back, output.
//  Two-operand stack ops and compares add a second stack read;
//  imul and idiv add a pass through the shared bit-serial multiply/divide unit.
//  Decode errors skip execute and write back.
//  in_stall is high from acceptance until the result is taken.
//  arst_n clears stack count, pc and control; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module stack_bytecode_integer_executor
	import sbie_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         opcode,
	input  logic [7:0]         local_index,
	input  logic signed [7:0]  immediate,
	input  logic signed [7:0]  increment,
	input  logic signed [15:0] branch_offset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        next_pc,
	output logic               print_valid,
	output logic signed [31:0] print_value,
	output logic               done_res,
	output logic signed [31:0] return_value,
	output logic [2:0]         error_code
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      pc_q;

	// latched item
	logic [7:0]  op_q;
	logic [7:0]  idx_q;
	logic [31:0] inc_q;
	logic [15:0] off_q;
	kind_t       kind_q;
	logic [2:0]  err_q;
	logic [15:0] len_q;
	logic [31:0] r_q;

	// output registers
	logic        ov_q;
	logic [15:0] npc_q;
	logic        pv_q;
	logic [31:0] pval_q;
	logic        done_q;
	logic [31:0] rv_q;
	logic [2:0]  eo_q;

	// decode of the incoming item
	kind_t       dk;
	logic [2:0]  derr;
	logic [15:0] dlen;
	logic        dlocal;
	logic [7:0]  dlidx;
	logic [1:0]  dneed;

	always_comb begin
		dk = K_NOP;
		derr = ERR_NONE;
		dlen = 16'd1;
		dlocal = 1'b0;
		dlidx = local_index;
		dneed = 2'd0;
		if (opcode >= OP_ICONST_M1 && opcode <= OP_ICONST_5) dk = K_PUSH;
		else if (opcode == OP_BIPUSH) begin dk = K_PUSH; dlen = 16'd2; end
		else if (opcode == OP_ILOAD) begin
			dk = K_PUSH; dlocal = 1'b1; dlen = 16'd2;
		end else if (opcode >= OP_ILOAD_0 && opcode <= OP_ILOAD_3) begin
			dk = K_PUSH; dlocal = 1'b1; dlidx = opcode - OP_ILOAD_0;
		end else if (opcode == OP_ISTORE) begin
			dk = K_STORE; dlocal = 1'b1; dlen = 16'd2;
		end else if (opcode >= OP_ISTORE_0 && opcode <= OP_ISTORE_3) begin
			dk = K_STORE; dlocal = 1'b1; dlidx = opcode - OP_ISTORE_0;
		end else if (opcode == OP_IADD || opcode == OP_ISUB || opcode == OP_IMUL ||
				opcode == OP_IDIV || opcode == OP_ISHL || opcode == OP_ISHR)
			dk = K_BINOP;
		else if (opcode == OP_IINC) begin
			dk = K_IINC; dlocal = 1'b1; dlen = 16'd3;
		end else if (opcode >= OP_IFEQ && opcode <= OP_IFLE) begin
			dk = K_CMP1; dlen = 16'd3;
		end else if (opcode >= OP_IF_ICMPEQ && opcode <= OP_IF_ICMPLE) begin
			dk = K_CMP2; dlen = 16'd3;
		end else if (opcode == OP_GOTO) begin dk = K_GOTO; dlen = 16'd3; end
		else if (opcode == OP_IRETURN) dk = K_IRET;
		else if (opcode == OP_RETURN) dk = K_RET;
		else if (opcode == OP_GETSTATIC) begin dk = K_NOP; dlen = 16'd3; end
		else if (opcode == OP_INVOKEVIRTUAL) begin dk = K_PRINT; dlen = 16'd3; end
		else derr = ERR_OPCODE;

		case (dk)
			K_STORE, K_CMP1, K_PRINT, K_IRET: dneed = 2'd1;
			K_BINOP, K_CMP2: dneed = 2'd2;
			default: dneed = 2'd0;
		endcase

		if (derr == ERR_NONE) begin
			if (dlocal && ({1'b0, dlidx} >= 9'(LOCAL_SLOTS))) derr = ERR_LOCAL;
			else if ({3'd0, cnt_q} < (CNT_W + 3)'(dneed)) derr = ERR_UNDERFLOW;
			else if (dk == K_PUSH && ({3'd0, cnt_q} >= (CNT_W + 3)'(STACK_DEPTH)))
				derr = ERR_OVERFLOW;
		end
	end

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// stack RAM: read/write port address
	logic             stk_we, loc_we;
	logic [SP_W-1:0]  stk_addr;
	logic [LOC_W-1:0] loc_addr;
	logic [31:0]      stk_wdata, loc_wdata, stk_rdata, loc_rdata;
	logic [31:0]      a_q, b_q;
	logic             rd_phase_q;  // 0: top read, 1: second read

	sbie_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata)
	);

	sbie_ram #(.WIDTH(32), .DEPTH(LOCAL_SLOTS)) u_locals (
		.clk(clk), .we(loc_we), .addr(loc_addr), .wdata(loc_wdata), .rdata(loc_rdata)
	);

	alu_ctl_t    alu_ctl;
	alu_sts_t    alu_sts;
	logic [31:0] alu_res;

	sbie_muldiv u_muldiv (
		.clk(clk), .arst_n(arst_n), .ctl(alu_ctl), .a(a_q), .b(b_q),
		.sts(alu_sts), .result(alu_res)
	);

	logic [CNT_W-1:0] cm1, cm2;
	assign cm1 = cnt_q - CNT_W'(1);
	assign cm2 = cnt_q - CNT_W'(2);

	// comparison and simple ALU
	logic        taken;
	logic [31:0] simple_r;
	logic signed [31:0] ca, cb;
	logic [4:0]  sh;
	logic [7:0]  cop;

	always_comb begin
		ca = (kind_q == K_CMP1) ? b_q : a_q;
		cb = (kind_q == K_CMP1) ? 32'sd0 : b_q;
		cop = (kind_q == K_CMP1) ? op_q : (op_q - (OP_IF_ICMPEQ - OP_IFEQ));
		case (cop)
			OP_IFEQ: taken = (ca == cb);
			OP_IFEQ + 8'd1: taken = (ca != cb);
			OP_IFEQ + 8'd2: taken = (ca < cb);
			OP_IFEQ + 8'd3: taken = (ca >= cb);
			OP_IFEQ + 8'd4: taken = (ca > cb);
			default: taken = (ca <= cb);
		endcase
		sh = b_q[4:0];
		case (op_q)
			OP_IADD: simple_r = a_q + b_q;
			OP_ISUB: simple_r = a_q - b_q;
			OP_ISHL: simple_r = a_q << sh;
			default: simple_r = $signed(a_q) >>> sh;
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		stk_we = 1'b0;
		loc_we = 1'b0;
		stk_addr = cm1[SP_W-1:0];
		loc_addr = idx_q[LOC_W-1:0];
		stk_wdata = r_q;
		loc_wdata = r_q;
		alu_ctl.start = 1'b0;
		alu_ctl.op = (op_q == OP_IMUL) ? ALU_MUL : ALU_DIV;
		case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_READ;
			ST_READ: begin
				// top arrives from the idle-cycle read, second entry in the following read cycle
				stk_addr = cm2[SP_W-1:0];
				if (err_q != ERR_NONE) state_d = ST_OUT;
				else if (kind_q == K_BINOP || kind_q == K_CMP2) begin
					if (rd_phase_q) state_d = ST_EXEC;
				end else state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (kind_q == K_BINOP && (op_q == OP_IMUL || op_q == OP_IDIV)
						&& !(op_q == OP_IDIV && b_q == 32'd0)) begin
					alu_ctl.start = 1'b1;
					state_d = ST_ITER;
				end else state_d = ST_WRITE;
			end
			ST_ITER: if (alu_sts.done) state_d = ST_WRITE;
			ST_WRITE: begin
				state_d = ST_OUT;
				if (err_q == ERR_NONE) begin
					case (kind_q)
						K_PUSH: begin stk_we = 1'b1; stk_addr = cnt_q[SP_W-1:0]; end
						K_BINOP: begin stk_we = 1'b1; stk_addr = cm2[SP_W-1:0]; end
						K_STORE, K_IINC: loc_we = 1'b1;
						default: ;
					endcase
				end
			end
			ST_OUT: if (!ov_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = (state_q != ST_IDLE) || ov_q;

	// control registers and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pc_q <= '0;
			ov_q <= 1'b0;
			rd_phase_q <= 1'b0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			if (state_q == ST_READ) rd_phase_q <= ~rd_phase_q & (state_d == ST_READ);
			if (state_q == ST_WRITE) begin
				ov_q <= 1'b1;
				if (err_q == ERR_NONE) begin
					pc_q <= npc_q;
					case (kind_q)
						K_PUSH: cnt_q <= cnt_q + CNT_W'(1);
						K_BINOP, K_STORE, K_CMP1, K_PRINT, K_IRET: cnt_q <= cm1;
						K_CMP2: cnt_q <= cm2;
						default: ;
					endcase
				end
			end
			if (state_q == ST_READ && err_q != ERR_NONE) ov_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q <= opcode;
			idx_q <= dlidx;
			inc_q <= 32'(increment);
			off_q <= branch_offset;
			kind_q <= dk;
			err_q <= derr;
			len_q <= dlen;
			r_q <= (opcode == OP_BIPUSH) ? 32'(immediate) : 32'(opcode) - 32'd3;
			npc_q <= pc_q;
			pv_q <= 1'b0;
			pval_q <= '0;
			done_q <= 1'b0;
			rv_q <= '0;
			eo_q <= derr;
		end
		if (state_q == ST_READ) begin
			if (rd_phase_q) a_q <= stk_rdata;
			else b_q <= stk_rdata;
		end
		if (state_q == ST_EXEC) begin
			npc_q <= pc_q + len_q;
			case (kind_q)
				K_PUSH: if (op_q == OP_ILOAD || (op_q >= OP_ILOAD_0 && op_q <= OP_ILOAD_3))
					r_q <= loc_rdata;
				K_STORE: r_q <= b_q;
				K_IINC: r_q <= loc_rdata + inc_q;
				K_BINOP: begin
					if (op_q == OP_IDIV && b_q == 32'd0) begin
						err_q <= ERR_DIVZERO;
						eo_q <= ERR_DIVZERO;
						npc_q <= pc_q;
					end else r_q <= simple_r;
				end
				K_CMP1, K_CMP2: if (taken) npc_q <= pc_q + off_q;
				K_GOTO: npc_q <= pc_q + off_q;
				K_PRINT: begin pv_q <= 1'b1; pval_q <= b_q; end
				K_RET: begin done_q <= 1'b1; npc_q <= pc_q; end
				K_IRET: begin done_q <= 1'b1; rv_q <= b_q; npc_q <= pc_q; end
				default: ;
			endcase
		end
		if (state_q == ST_ITER && alu_sts.done) r_q <= alu_res;
	end

	assign out_valid = ov_q;
	assign next_pc = npc_q;
	assign print_valid = pv_q;
	assign print_value = pval_q;
	assign done_res = done_q;
	assign return_value = rv_q;
	assign error_code = eo_q;

endmodule

/* rtl/sbie_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbie_checker: port-level assertions for the bytecode executor
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module sbie_checker
	import sbie_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] next_pc,
	input logic        print_valid,
	input logic        done_res,
	input logic [2:0]  error_code
);

	// a result held under stall keeps its pc
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc))
		else $error("stalled result changed");

	// no new transaction while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while result pending");

	// an accepted transaction blocks further input next cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("back-to-back accept");

	// error results carry no print or done mark
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !print_valid && !done_res)
		else $error("error with side result");

	// print and done never together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(print_valid && done_res))
		else $error("print and done together");

endmodule

bind stack_bytecode_integer_executor sbie_checker u_sbie_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
	.print_valid(print_valid), .done_res(done_res), .error_code(error_code)
);
